/* hw/rtl/fpf_pkg.sv */
package fpf_pkg;

    localparam int LIST_LEN_DEF  = 6;
    localparam int CMD_DEPTH_DEF = 4;
    localparam int NUM_NAMES     = 6;

    localparam logic [2:0] UNKNOWN_FIELD = 3'd6;
    localparam logic [2:0] FIELD_TIMESTAMP = 3'd0;

    localparam logic [7:0] OP_PROTO     = 8'h80;
    localparam logic [7:0] OP_FRAME     = 8'h95;
    localparam logic [7:0] OP_DICT      = 8'h7d;
    localparam logic [7:0] OP_MEMO      = 8'h94;
    localparam logic [7:0] OP_MARK      = 8'h28;
    localparam logic [7:0] OP_SETITEMS  = 8'h75;
    localparam logic [7:0] OP_STOP      = 8'h2e;
    localparam logic [7:0] OP_SHORTSTR  = 8'h8c;
    localparam logic [7:0] OP_FLOAT     = 8'h47;
    localparam logic [7:0] OP_LIST      = 8'h5d;
    localparam logic [7:0] OP_APPENDS   = 8'h65;

    typedef enum logic [4:0] {
        PH_HDR0      = 5'd0,
        PH_PROTOVER  = 5'd1,
        PH_FRAMECHK  = 5'd2,
        PH_FRAMESKIP = 5'd3,
        PH_DICT      = 5'd4,
        PH_DICT_MEMO = 5'd5,
        PH_DICT_MARK = 5'd6,
        PH_LOOP      = 5'd7,
        PH_KEYLEN    = 5'd8,
        PH_KEY       = 5'd9,
        PH_KEY_MEMO  = 5'd10,
        PH_L_MEMO    = 5'd11,
        PH_L_OPEN    = 5'd12,
        PH_L_MEMO2   = 5'd13,
        PH_L_MARK    = 5'd14,
        PH_F_MEMO    = 5'd15,
        PH_F_OP      = 5'd16,
        PH_F_DATA    = 5'd17,
        PH_L_APPENDS = 5'd18,
        PH_DONE      = 5'd19
    } phase_t;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       end_of_msg;
    } item_t;

    typedef struct packed {
        logic        item_kind;
        logic [2:0]  field_code;
        logic [2:0]  element_index;
        logic [63:0] value_bits;
        logic        parse_status;
        logic        last_of_run;
    } result_t;

    // One command per byte that causes results: a single value, a run of
    // zero values, and/or the end-of-message status.
    typedef struct packed {
        logic        has_val;
        logic        has_zeros;
        logic        has_status;
        logic        fail;
        logic [2:0]  field;
        logic [2:0]  idx;
        logic [63:0] bits;
    } cmd_t;

    function automatic logic [7:0] name_len(input logic [2:0] idx);
        logic [7:0] len;
        case (idx)
            3'd0:    len = 8'd9;
            3'd1:    len = 8'd8;
            3'd2:    len = 8'd8;
            3'd3:    len = 8'd9;
            3'd4:    len = 8'd7;
            3'd5:    len = 8'd10;
            default: len = 8'd0;
        endcase
        return len;
    endfunction

    // Key names as ASCII bytes, padded on the right with spaces to ten characters.
    function automatic logic [7:0] key_char(input logic [2:0] idx, input logic [3:0] pos);
        logic [79:0] s;
        logic [79:0] sh;
        case (idx)
            3'd0:    s = "timestamp ";
            3'd1:    s = 80'h706f73655f636d642020;
            3'd2:    s = 80'h706f73655f6e6f772020;
            3'd3:    s = 80'h6a6f696e745f706f7320;
            3'd4:    s = "actions   ";
            3'd5:    s = 80'h706f73655f6572726f72;
            default: s = '0;
        endcase
        sh = s << {pos, 3'b000};
        return sh[79:72];
    endfunction

endpackage

/* hw/rtl/fixed_layout_pickle_float_parser.sv */
// Path: a taken byte's command is written into the command queue, and the
//   output register loads its first result from the queue head once it is free.
// Throughput: one byte per cycle while the command queue is not full; at most
//   one result per cycle leaves the output register, on pop, so a bad list opener
//   (LIST_LEN zeros plus perhaps status) holds the back end while the CMD_DEPTH-entry command queue absorbs input.
// Reset: rst_n is asynchronous, active low; it clears parser state and queues.
module fixed_layout_pickle_float_parser #(
    parameter int LIST_LEN  = fpf_pkg::LIST_LEN_DEF,
    parameter int CMD_DEPTH = fpf_pkg::CMD_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fpf_pkg::item_t   item,
    input  logic             push,
    output logic             full,
    output fpf_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    // Front end: per-byte parser. Each accepted byte advances the phase machine
    // and, where the byte finishes a value, a zero run or a message, writes one
    // command into the queue. Bytes that cause no result leave no trace there.
    logic          accept;
    logic          cmd_push;
    fpf_pkg::cmd_t cmd_in;
    fpf_pkg::cmd_t cmd_head;
    logic          cmd_pop;
    logic          cmd_empty;

    // Hold input while the command queue is full; the queue fill alone sets this.
    assign accept = push && !full;

    fpf_front #(
        .LIST_LEN (LIST_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // Short queue between the two halves: lets the parser run ahead while a
    // multi-result command is drained, and lets results wait for pop.
    fpf_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    // Back end: expand each command into result transactions, oldest first,
    // and drop the command once its last result is loaded.
    fpf_back #(
        .LIST_LEN (LIST_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef SYNTHESIS
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !cmd_push)
        else $error("command written while queue full");
`endif

endmodule

/* hw/rtl/fpf_front.sv */
module fpf_front #(
    parameter int LIST_LEN = fpf_pkg::LIST_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  fpf_pkg::item_t item,
    output logic          cmd_push,
    output fpf_pkg::cmd_t cmd
);

    fpf_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  skip_reg, skip_next;
    logic [7:0]  klen_reg, klen_next;
    logic [7:0]  kpos_reg, kpos_next;
    logic [5:0]  kflags_reg, kflags_next;
    logic [2:0]  cfield_reg, cfield_next;
    logic [2:0]  ecount_reg, ecount_next;
    logic [63:0] vshift_reg, vshift_next;
    logic [2:0]  tally_reg, tally_next;
    logic        failed_reg, failed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fpf_pkg::PH_HDR0;
            skip_reg   <= '0;
            klen_reg   <= '0;
            kpos_reg   <= '0;
            kflags_reg <= 6'h3f;
            cfield_reg <= '0;
            ecount_reg <= '0;
            vshift_reg <= '0;
            tally_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            klen_reg   <= klen_next;
            kpos_reg   <= kpos_next;
            kflags_reg <= kflags_next;
            cfield_reg <= cfield_next;
            ecount_reg <= ecount_next;
            vshift_reg <= vshift_next;
            tally_reg  <= tally_next;
            failed_reg <= failed_next;
        end
    end

    always_comb
    begin
        logic       go;
        logic       kdone;
        logic       edone;
        logic [63:0] ebits;
        logic [7:0] b;
        logic [7:0] kpos_inc;
        b           = item.msg_byte;
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        klen_next   = klen_reg;
        kpos_next   = kpos_reg;
        kflags_next = kflags_reg;
        cfield_next = cfield_reg;
        ecount_next = ecount_reg;
        vshift_next = vshift_reg;
        failed_next = failed_reg;
        tally_next  = (tally_reg < 3'd5) ? tally_reg + 3'd1 : tally_reg;
        cmd         = '0;
        go          = 1'b1;
        kpos_inc    = '0;
        ebits       = '0;
        // A byte passes through at most four phases before it is consumed.
        for (int s = 0; s < 4; s++)
        begin
            kdone = 1'b0;
            edone = 1'b0;
            if (go)
            begin
                go = 1'b0;
                case (phase_next)
                    fpf_pkg::PH_HDR0:
                    begin
                        if (b == fpf_pkg::OP_PROTO)
                            phase_next = fpf_pkg::PH_PROTOVER;
                        else
                        begin
                            phase_next = fpf_pkg::PH_FRAMECHK;
                            go = 1'b1;
                        end
                    end
                    fpf_pkg::PH_PROTOVER: phase_next = fpf_pkg::PH_FRAMECHK;
                    fpf_pkg::PH_FRAMECHK:
                    begin
                        if (b == fpf_pkg::OP_FRAME)
                        begin
                            skip_next  = 4'd8;
                            phase_next = fpf_pkg::PH_FRAMESKIP;
                        end
                        else
                        begin
                            phase_next = fpf_pkg::PH_DICT;
                            go = 1'b1;
                        end
                    end
                    fpf_pkg::PH_FRAMESKIP:
                    begin
                        if (skip_next != 4'd0)
                            skip_next = skip_next - 4'd1;
                        if (skip_next == 4'd0)
                            phase_next = fpf_pkg::PH_DICT;
                    end
                    fpf_pkg::PH_DICT:
                    begin
                        if (b == fpf_pkg::OP_DICT)
                            phase_next = fpf_pkg::PH_DICT_MEMO;
                        else
                        begin
                            failed_next = 1'b1;
                            phase_next  = fpf_pkg::PH_DONE;
                        end
                    end
                    fpf_pkg::PH_DICT_MEMO:
                    begin
                        phase_next = fpf_pkg::PH_DICT_MARK;
                        go = (b != fpf_pkg::OP_MEMO);
                    end
                    fpf_pkg::PH_DICT_MARK:
                    begin
                        phase_next = fpf_pkg::PH_LOOP;
                        go = (b != fpf_pkg::OP_MARK);
                    end
                    fpf_pkg::PH_LOOP:
                    begin
                        if (b == fpf_pkg::OP_SETITEMS || b == fpf_pkg::OP_STOP)
                            phase_next = fpf_pkg::PH_DONE;
                        else if (b == fpf_pkg::OP_SHORTSTR)
                            phase_next = fpf_pkg::PH_KEYLEN;
                        else
                        begin
                            failed_next = 1'b1;
                            phase_next  = fpf_pkg::PH_DONE;
                        end
                    end
                    fpf_pkg::PH_KEYLEN:
                    begin
                        klen_next   = b;
                        kpos_next   = '0;
                        kflags_next = 6'h3f;
                        if (b == 8'd0)
                            kdone = 1'b1;
                        else
                            phase_next = fpf_pkg::PH_KEY;
                    end
                    fpf_pkg::PH_KEY:
                    begin
                        for (int i = 0; i < fpf_pkg::NUM_NAMES; i++)
                        begin
                            if (kpos_next >= fpf_pkg::name_len(3'(i)))
                                kflags_next[i] = 1'b0;
                            else if (fpf_pkg::key_char(3'(i), kpos_next[3:0]) != b)
                                kflags_next[i] = 1'b0;
                        end
                        kpos_inc  = kpos_next + 8'd1;
                        kpos_next = kpos_inc;
                        if (kpos_inc >= klen_next)
                            kdone = 1'b1;
                    end
                    fpf_pkg::PH_KEY_MEMO:
                    begin
                        ecount_next = '0;
                        phase_next  = (cfield_next == fpf_pkg::FIELD_TIMESTAMP) ?
                                      fpf_pkg::PH_F_MEMO : fpf_pkg::PH_L_MEMO;
                        go = (b != fpf_pkg::OP_MEMO);
                    end
                    fpf_pkg::PH_L_MEMO:
                    begin
                        phase_next = fpf_pkg::PH_L_OPEN;
                        go = (b != fpf_pkg::OP_MEMO);
                    end
                    fpf_pkg::PH_L_OPEN:
                    begin
                        if (b == fpf_pkg::OP_LIST)
                            phase_next = fpf_pkg::PH_L_MEMO2;
                        else
                        begin
                            // bad list opener: a run of zeros for a known key
                            if (cfield_next < fpf_pkg::UNKNOWN_FIELD)
                            begin
                                cmd.has_zeros = 1'b1;
                                cmd.field     = cfield_next;
                            end
                            phase_next = fpf_pkg::PH_LOOP;
                        end
                    end
                    fpf_pkg::PH_L_MEMO2:
                    begin
                        phase_next = fpf_pkg::PH_L_MARK;
                        go = (b != fpf_pkg::OP_MEMO);
                    end
                    fpf_pkg::PH_L_MARK:
                    begin
                        ecount_next = '0;
                        phase_next  = fpf_pkg::PH_F_MEMO;
                        go = (b != fpf_pkg::OP_MARK);
                    end
                    fpf_pkg::PH_F_MEMO:
                    begin
                        phase_next = fpf_pkg::PH_F_OP;
                        go = (b != fpf_pkg::OP_MEMO);
                    end
                    fpf_pkg::PH_F_OP:
                    begin
                        if (b == fpf_pkg::OP_FLOAT)
                        begin
                            vshift_next = '0;
                            skip_next   = '0;
                            phase_next  = fpf_pkg::PH_F_DATA;
                        end
                        else
                        begin
                            edone = 1'b1;
                            ebits = '0;
                        end
                    end
                    fpf_pkg::PH_F_DATA:
                    begin
                        vshift_next = {vshift_next[55:0], b};
                        skip_next   = skip_next + 4'd1;
                        if (skip_next >= 4'd8)
                        begin
                            edone = 1'b1;
                            ebits = vshift_next;
                        end
                    end
                    fpf_pkg::PH_L_APPENDS:
                    begin
                        phase_next = fpf_pkg::PH_LOOP;
                        go = (b != fpf_pkg::OP_APPENDS);
                    end
                    default: phase_next = fpf_pkg::PH_DONE;
                endcase

                // resolve the key against the names still in the running
                if (kdone)
                begin
                    cfield_next = fpf_pkg::UNKNOWN_FIELD;
                    for (int i = fpf_pkg::NUM_NAMES - 1; i >= 0; i--)
                        if (kflags_next[i] && fpf_pkg::name_len(3'(i)) == klen_next)
                            cfield_next = 3'(i);
                    phase_next = fpf_pkg::PH_KEY_MEMO;
                end

                if (edone)
                begin
                    if (cfield_next < fpf_pkg::UNKNOWN_FIELD)
                    begin
                        cmd.has_val = 1'b1;
                        cmd.field   = cfield_next;
                        cmd.idx     = (cfield_next == fpf_pkg::FIELD_TIMESTAMP) ?
                                      3'd0 : ecount_next;
                        cmd.bits    = ebits;
                    end
                    if (cfield_next == fpf_pkg::FIELD_TIMESTAMP)
                        phase_next = fpf_pkg::PH_LOOP;
                    else if (ecount_next >= 3'(LIST_LEN - 1))
                        phase_next = fpf_pkg::PH_L_APPENDS;
                    else
                    begin
                        ecount_next = ecount_next + 3'd1;
                        phase_next  = fpf_pkg::PH_F_MEMO;
                    end
                end
            end
        end

        if (item.end_of_msg)
        begin
            cmd.has_status = 1'b1;
            cmd.fail       = failed_next || (tally_next < 3'd5) ||
                             (phase_next <= fpf_pkg::PH_DICT);
            phase_next  = fpf_pkg::PH_HDR0;
            skip_next   = '0;
            klen_next   = '0;
            kpos_next   = '0;
            kflags_next = 6'h3f;
            cfield_next = '0;
            ecount_next = '0;
            vshift_next = '0;
            tally_next  = '0;
            failed_next = 1'b0;
        end

        cmd_push = accept && (cmd.has_val || cmd.has_zeros || cmd.has_status);
    end

`ifndef SYNTHESIS
    a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_msg |=> phase_reg == fpf_pkg::PH_HDR0 && tally_reg == 3'd0)
        else $error("parser state not cleared after message end");
    a_val_known: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push && (cmd.has_val || cmd.has_zeros) |->
        cmd.field < fpf_pkg::UNKNOWN_FIELD && !(cmd.has_val && cmd.has_zeros))
        else $error("value command for an unknown key");
`endif

endmodule

/* hw/rtl/fpf_cmd_fifo.sv */
module fpf_cmd_fifo #(
    parameter int DEPTH = fpf_pkg::CMD_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  fpf_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output fpf_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpf_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en |-> !full) and (rd_en |-> !empty))
        else $error("command queue overrun or underrun");
`endif

endmodule

/* hw/rtl/fpf_back.sv */
module fpf_back #(
    parameter int LIST_LEN = fpf_pkg::LIST_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fpf_pkg::cmd_t    cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    output fpf_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    localparam int CNT_W = $clog2(LIST_LEN + 2);

    logic [CNT_W-1:0] n_reg, n_next;
    logic             valid_reg, valid_next;
    fpf_pkg::result_t res_reg, res_next;

    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] total;
    logic             advance;
    logic             final_item;

    assign empty  = !valid_reg;
    assign result = res_reg;

    always_comb
    begin
        body       = cmd.has_zeros ? CNT_W'(LIST_LEN) : CNT_W'(cmd.has_val);
        total      = body + CNT_W'(cmd.has_status);
        advance    = !cmd_empty && (!valid_reg || pop);
        final_item = (n_reg == total - 1'b1);
        cmd_pop    = advance && final_item;

        res_next   = res_reg;
        n_next     = n_reg;
        valid_next = valid_reg && !pop;
        if (advance)
        begin
            valid_next = 1'b1;
            res_next   = '0;
            if (n_reg < body)
            begin
                res_next.field_code    = cmd.field;
                res_next.element_index = cmd.has_zeros ? 3'(n_reg) : cmd.idx;
                res_next.value_bits    = cmd.has_zeros ? 64'd0 : cmd.bits;
            end
            else
            begin
                res_next.item_kind    = 1'b1;
                res_next.parse_status = cmd.fail;
            end
            res_next.last_of_run = final_item;
            n_next = final_item ? '0 : n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            n_reg     <= n_next;
            valid_reg <= valid_next;
        end
    end

`ifndef SYNTHESIS
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.item_kind |-> res_reg.last_of_run && res_reg.value_bits == 64'd0)
        else $error("status result not closing its run");
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(LIST_LEN))
        else $error("expansion counter beyond the run length");
`endif

endmodule
